FILE: sv/ssml_pkg.sv
// sorted span merge list: shared types and constants
// no dependencies
package ssml_pkg;
	localparam int CAPACITY_DEF = 128;
	localparam int SPAN_W = 16;
	localparam int IDX_W = 7;
	localparam int CNT_OUT_W = 8;

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef struct packed {
		logic signed [SPAN_W-1:0] lo;
		logic signed [SPAN_W-1:0] hi;
	} span_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic  shift;
		logic  clear;
		span_t wr_span;
	} cell_ctrl_t;
endpackage

FILE: sv/sorted_span_merge_list.sv
// sorted span merge list: top level with sequencer and cell chain
// depends on ssml_pkg and ssml_cell
//
// usage: drive func, span_lo, span_hi and read_index with start high; the item
// transfers at the edge where start is high and busy is low. one result per
// item appears on accepted, count_now, read_valid, read_lo, read_hi for one
// cycle with done high; the receiver cannot stall.
// the list is a chain of CAPACITY cells that shifts by one place a cycle during
// an add or a read, but not in the step that takes in a new span. an add pops
// every cell from the head once, plus one step that takes in the new span at
// its sorted place; each popped span is merged into the running span, and a
// finished span is written just behind the spans already condensed, so the
// list stays packed at the head. a last step writes the running span. a read
// rotates the chain once, bringing the wanted cell to the head. clear, no-op
// and a refused add on a full list give their result in the cycle after the
// transfer. the next item can transfer at the edge that takes the result.
// reset empties the list at once (per-cell valid bits).
module sorted_span_merge_list #(
	parameter int CAPACITY = ssml_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	output logic                               done,
	input  logic [1:0]                         func,
	input  logic signed [ssml_pkg::SPAN_W-1:0] span_lo,
	input  logic signed [ssml_pkg::SPAN_W-1:0] span_hi,
	input  logic [ssml_pkg::IDX_W-1:0]         read_index,
	output logic                               accepted,
	output logic [ssml_pkg::CNT_OUT_W-1:0]     count_now,
	output logic                               read_valid,
	output logic signed [ssml_pkg::SPAN_W-1:0] read_lo,
	output logic signed [ssml_pkg::SPAN_W-1:0] read_hi
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = (CW > ssml_pkg::IDX_W) ? CW : ssml_pkg::IDX_W;

	typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_FLUSH, ST_READ} state_t;
	state_t state_q;

	logic [CW-1:0] count_q, step_q, newcnt_q;
	logic [ssml_pkg::IDX_W-1:0] ridx_q;
	ssml_pkg::span_t ins_q, run_q;
	logic run_v_q, ins_done_q;

	logic [CAPACITY-1:0] cv;
	ssml_pkg::span_t cs [CAPACITY];
	ssml_pkg::cell_ctrl_t ctrl;

	// tail input of the chain
	logic tail_v;
	ssml_pkg::span_t tail_s;

	// write of a condensed span behind those already written
	logic wr_en;
	logic [CW-1:0] wr_idx;
	logic [CAPACITY-1:0] wr_sel;

	// head of the chain, and what merges this cycle
	logic take_ins, ins_first;
	ssml_pkg::span_t cand;
	logic cand_v, merge;
	logic signed [ssml_pkg::SPAN_W:0] lo_m1;

	// insert goes before the head unless the head orders strictly before it, or once the list tail is reached
	always_comb begin
		take_ins = 1'b0;
		cand = cs[0];
		cand_v = 1'b0;
		ins_first = ($signed(ins_q.lo) < $signed(cs[0].lo)) ||
			((ins_q.lo == cs[0].lo) && ($signed(ins_q.hi) <= $signed(cs[0].hi)));
		if (state_q == ST_ADD) begin
			if (!ins_done_q && (!cv[0] || ins_first)) begin
				take_ins = 1'b1;
				cand = ins_q;
				cand_v = 1'b1;
			end else begin
				cand_v = cv[0];
			end
		end
		lo_m1 = {cand.lo[ssml_pkg::SPAN_W-1], cand.lo} - 1'b1;
		merge = run_v_q &&
			($signed({run_q.hi[ssml_pkg::SPAN_W-1], run_q.hi}) >= lo_m1);
	end

	always_comb begin
		ctrl.clear = 1'b0;
		ctrl.wr_span = run_q;
		ctrl.shift = 1'b0;
		tail_v = cv[0];
		tail_s = cs[0];
		wr_en = 1'b0;
		case (state_q)
			ST_ADD: begin
				ctrl.shift = !take_ins;
				tail_v = 1'b0;
				wr_en = cand_v && run_v_q && !merge;
			end
			ST_FLUSH: wr_en = 1'b1;
			ST_READ: ctrl.shift = 1'b1;
			default: ctrl.clear = start && (func == ssml_pkg::FUNC_CLEAR);
		endcase
	end

	// written spans start at CAPACITY - pops; one place nearer the head after a shift
	assign wr_idx = CW'(CAPACITY) - step_q + newcnt_q - CW'(ctrl.shift);

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			assign wr_sel[g] = wr_en && (wr_idx == CW'(g));
			ssml_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .wr_sel(wr_sel[g]),
				.prev_valid((g == CAPACITY - 1) ? tail_v : cv[(g + 1) % CAPACITY]),
				.prev_span((g == CAPACITY - 1) ? tail_s : cs[(g + 1) % CAPACITY]),
				.valid_q(cv[g]), .span_q(cs[g])
			);
		end
	endgenerate

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done <= 1'b0;
			step_q <= '0;
			run_v_q <= 1'b0;
			ins_done_q <= 1'b0;
			newcnt_q <= '0;
			accepted <= 1'b0;
			read_valid <= 1'b0;
			count_now <= '0;
			read_lo <= '0;
			read_hi <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					accepted <= 1'b0;
					read_valid <= 1'b0;
					read_lo <= '0;
					read_hi <= '0;
					count_now <= ssml_pkg::CNT_OUT_W'(count_q);
					case (func)
						ssml_pkg::FUNC_ADD: begin
							if (count_q >= CW'(CAPACITY)) begin
								done <= 1'b1;
							end else begin
								state_q <= ST_ADD;
								ins_q <= '{lo: span_lo, hi: span_hi};
								step_q <= '0;
								run_v_q <= 1'b0;
								ins_done_q <= 1'b0;
								newcnt_q <= '0;
							end
						end
						ssml_pkg::FUNC_READ: begin
							state_q <= ST_READ;
							ridx_q <= read_index;
							step_q <= '0;
						end
						ssml_pkg::FUNC_CLEAR: begin
							count_q <= '0;
							count_now <= '0;
							done <= 1'b1;
						end
						default: done <= 1'b1;
					endcase
				end
				ST_ADD: begin
					if (take_ins) ins_done_q <= 1'b1;
					else step_q <= step_q + 1'b1;
					if (cand_v) begin
						if (merge) begin
							if ($signed(cand.hi) > $signed(run_q.hi)) run_q.hi <= cand.hi;
						end else begin
							run_q <= cand;
							run_v_q <= 1'b1;
							if (run_v_q) newcnt_q <= newcnt_q + 1'b1;
						end
					end
					if (!take_ins && step_q == CW'(CAPACITY - 1)) state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
					count_q <= newcnt_q + 1'b1;
					count_now <= ssml_pkg::CNT_OUT_W'(newcnt_q + 1'b1);
					accepted <= 1'b1;
					done <= 1'b1;
				end
				ST_READ: begin
					// valid cells are packed at the head, so a valid head is below the count
					if ((RW'(ridx_q) == RW'(step_q)) && cv[0]) begin
						read_valid <= 1'b1;
						read_lo <= cs[0].lo;
						read_hi <= cs[0].hi;
					end
					step_q <= step_q + 1'b1;
					if (step_q == CW'(CAPACITY - 1)) begin
						state_q <= ST_IDLE;
						done <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/ssml_cell.sv
// sorted span merge list: one storage cell of the chain
// depends on ssml_pkg
module ssml_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ssml_pkg::cell_ctrl_t ctrl,
	input  logic                wr_sel,
	input  logic                prev_valid,
	input  ssml_pkg::span_t     prev_span,
	output logic                valid_q,
	output ssml_pkg::span_t     span_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (wr_sel) begin
			valid_q <= 1'b1;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end
	end

	// a write lands on top of the shift
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			span_q <= ctrl.wr_span;
		end else if (ctrl.shift) begin
			span_q <= prev_span;
		end
	end
endmodule

FILE: sv/ssml_checker.sv
// sorted span merge list: port-level checks, bound to the top level
// depends on ssml_pkg and sorted_span_merge_list ports
module ssml_port_props (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] func,
	input logic       accepted,
	input logic       read_valid,
	input logic [7:0] count_now
);
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done) else $error("done without a transfer");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_rv_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(accepted && read_valid)) else $error("accepted with read_valid");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == ssml_pkg::FUNC_CLEAR) |=> (done && count_now == 8'd0))
		else $error("clear result wrong");
	a_acc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (count_now != 8'd0)) else $error("count");
endmodule

bind sorted_span_merge_list ssml_port_props u_ssml_port_props (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.func(func), .accepted(accepted), .read_valid(read_valid), .count_now(count_now)
);

FILE: tb/ssml_checker.sv
// sorted span merge list: checker that predicts each result and compares it
// depends on ssml_pkg; watches the command and result ports of the block
module ssml_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [1:0]  func,
	input  logic signed [15:0] span_lo,
	input  logic signed [15:0] span_hi,
	input  logic [6:0]  read_index,
	input  logic        accepted,
	input  logic [7:0]  count_now,
	input  logic        read_valid,
	input  logic signed [15:0] read_lo,
	input  logic signed [15:0] read_hi,
	output int          fail_count,
	output int          pending
);
	localparam int CAP = ssml_pkg::CAPACITY_DEF;

	typedef struct packed {
		logic        acc;
		logic [7:0]  cnt;
		logic        rv;
		logic [15:0] rlo;
		logic [15:0] rhi;
	} list_result_t;

	logic signed [15:0] store_lo [CAP];
	logic signed [15:0] store_hi [CAP];
	int span_count;
	list_result_t result_q [$];

	function automatic logic add_span(logic signed [15:0] lo, logic signed [15:0] hi);
		logic signed [15:0] wlo [CAP+1];
		logic signed [15:0] whi [CAP+1];
		int pos, src, cur;
		if (span_count >= CAP)
			return 1'b0;
		pos = span_count;
		for (int i = 0; i < span_count; i++)
			if (lo < store_lo[i] || (lo == store_lo[i] && hi <= store_hi[i])) begin
				pos = i;
				break;
			end
		src = 0;
		for (int i = 0; i <= span_count; i++) begin
			if (i == pos) begin
				wlo[i] = lo;
				whi[i] = hi;
			end else begin
				wlo[i] = store_lo[src];
				whi[i] = store_hi[src];
				src++;
			end
		end
		cur = 0;
		store_lo[0] = wlo[0];
		store_hi[0] = whi[0];
		for (int i = 1; i <= span_count; i++) begin
			// widened so that start - 1 cannot wrap
			if (int'(store_hi[cur]) >= int'(wlo[i]) - 1) begin
				if (whi[i] > store_hi[cur])
					store_hi[cur] = whi[i];
			end else begin
				cur++;
				store_lo[cur] = wlo[i];
				store_hi[cur] = whi[i];
			end
		end
		span_count = cur + 1;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want, got;
		if (!arst_n) begin
			span_count = 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (done) begin
				got = '{accepted, count_now, read_valid, read_lo, read_hi};
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (start && !busy) begin
				want = '0;
				case (ssml_pkg::func_t'(func))
					ssml_pkg::FUNC_ADD:   want.acc = add_span(span_lo, span_hi);
					ssml_pkg::FUNC_READ:  if (read_index < span_count) begin
						want.rv = 1'b1;
						want.rlo = store_lo[read_index];
						want.rhi = store_hi[read_index];
					end
					ssml_pkg::FUNC_CLEAR: span_count = 0;
					default: ;
				endcase
				want.cnt = span_count[7:0];
				result_q.push_back(want);
			end
		end
		pending = result_q.size();
	end
endmodule

FILE: tb/tb_top.sv
// sorted span merge list: testbench top, clock, reset, stimulus and verdict
// depends on ssml_pkg, sorted_span_merge_list and ssml_checker
module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] func = ssml_pkg::FUNC_NOP;
	logic signed [15:0] span_lo = '0;
	logic signed [15:0] span_hi = '0;
	logic [6:0] read_index = '0;
	logic busy, done, accepted, read_valid;
	logic [7:0] count_now;
	logic signed [15:0] read_lo, read_hi;
	int fail_count, pending;

	always #5 clk = ~clk;

	sorted_span_merge_list dut (.*);
	ssml_checker chk (.*);

	// one transfer, then, if gaps is set, an idle gap of random length
	task automatic send(ssml_pkg::func_t f, logic [15:0] lo, logic [15:0] hi,
		logic [6:0] idx, input bit gaps = 1'b1);
		int gap;
		func <= f;
		span_lo <= lo;
		span_hi <= hi;
		read_index <= idx;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		gap = gaps ? $urandom_range(0, 14) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			func <= ssml_pkg::func_t'($urandom_range(0, 3));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] near(int base);
		return 16'(base + int'($urandom_range(0, 80)) - 40);
	endfunction

	initial begin
		int f, base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, reversed, adjacent, out of range, nop, clear
		send(ssml_pkg::FUNC_READ, 0, 0, 0);
		send(ssml_pkg::FUNC_ADD, 16'h8000, 16'h8000, 0);
		send(ssml_pkg::FUNC_ADD, 16'h7fff, 16'h7fff, 0);
		send(ssml_pkg::FUNC_ADD, 16'h7ffe, 16'h7ffe, 0);
		send(ssml_pkg::FUNC_ADD, 16'h8001, 16'h8001, 0);
		send(ssml_pkg::FUNC_ADD, 16'd10, 16'd20, 0);
		send(ssml_pkg::FUNC_ADD, 16'd21, 16'd25, 0);
		send(ssml_pkg::FUNC_ADD, 16'd40, 16'd30, 0);
		send(ssml_pkg::FUNC_ADD, 16'd40, 16'd30, 0);
		send(ssml_pkg::FUNC_ADD, 16'hffff, 16'h0000, 0);
		for (int i = 0; i < 7; i++) send(ssml_pkg::FUNC_READ, 0, 0, 7'(i));
		send(ssml_pkg::FUNC_READ, 0, 0, 7'h7f);
		send(ssml_pkg::FUNC_NOP, 16'hffff, 16'hffff, 7'h7f);
		send(ssml_pkg::FUNC_CLEAR, 0, 0, 0);
		send(ssml_pkg::FUNC_READ, 0, 0, 0);
		drain();
		// fill to capacity with isolated spans, then adds that are refused
		for (int i = 0; i < ssml_pkg::CAPACITY_DEF; i++)
			send(ssml_pkg::FUNC_ADD, 16'(i * 4 - 256), 16'(i * 4 - 255), 0, 1'b0);
		send(ssml_pkg::FUNC_ADD, 16'd0, 16'd1, 0);
		send(ssml_pkg::FUNC_ADD, 16'h8000, 16'h7fff, 0);
		send(ssml_pkg::FUNC_READ, 0, 0, 7'h7f);
		send(ssml_pkg::FUNC_READ, 0, 0, 7'h00);
		send(ssml_pkg::FUNC_CLEAR, 0, 0, 0);
		drain();
		// random: mostly clustered adds with reads, rare clears
		for (int n = 0; n < 1500; n++) begin
			f = $urandom_range(0, 99);
			base = $urandom_range(0, 7) == 0 ? int'($urandom_range(0, 65535)) - 32768
				: int'($urandom_range(0, 2000)) - 1000;
			if (f < 55)
				send(ssml_pkg::FUNC_ADD, near(base),
					$urandom_range(0, 9) == 0 ? 16'($urandom) : near(base), 0);
			else if (f < 88)
				send(ssml_pkg::FUNC_READ, 16'($urandom), 16'($urandom),
					$urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 20)));
			else if (f < 91)
				send(ssml_pkg::FUNC_CLEAR, 16'($urandom), 16'($urandom), 7'($urandom));
			else
				send(ssml_pkg::FUNC_NOP, 16'($urandom), 16'($urandom), 7'($urandom));
			if (n == 700) drain();
		end
		drain();
		repeat (ssml_pkg::CAPACITY_DEF + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule

FILE: files.f
sv/ssml_pkg.sv
sv/ssml_cell.sv
sv/sorted_span_merge_list.sv
sv/ssml_checker.sv
tb/ssml_checker.sv
tb/tb_top.sv
